// ===== sv/tfpm_pkg.sv =====
// ============================================================================
// tfpm_pkg
// Shared constants for the topic filter packet matcher.
// ============================================================================
package tfpm_pkg;

    localparam int NUM_FILTERS_DEF = 8;
    localparam int FILTER_LEN_DEF  = 32;

    localparam logic [15:0] MAX_LEN_RST = 16'd1500;
    localparam logic [7:0]  MAGIC_RST   = 8'd80;

    // Configuration register indexes.
    localparam logic REG_MAX_LEN = 1'b0;
    localparam logic REG_MAGIC   = 1'b1;

    // Input opcodes.
    localparam logic [1:0] OP_WRITE_CHAR = 2'd0;
    localparam logic [1:0] OP_ENABLE     = 2'd1;
    localparam logic [1:0] OP_PACKET     = 2'd2;
    localparam logic [1:0] OP_RESERVED   = 2'd3;

    // Per-slot match phases.
    localparam logic [1:0] PH_CMP  = 2'd0;
    localparam logic [1:0] PH_SKIP = 2'd1;
    localparam logic [1:0] PH_HIT  = 2'd2;
    localparam logic [1:0] PH_MISS = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_LONG      = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
    localparam logic [2:0] ST_NO_TERM   = 3'd4;

    // Filter characters with special meaning.
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

// ===== sv/topic_filter_packet_matcher.sv =====
// ============================================================================
// topic_filter_packet_matcher
// Streams packet bytes and matches the topic against wildcard filters.
// ============================================================================
// Usage: items enter on in_valid/in_stall. Opcode 0 writes a filter byte,
// opcode 1 sets a slot enable, opcode 2 carries one packet byte; a packet is
// a magic byte, a zero-terminated topic and a payload. The last packet byte
// (end_of_packet) yields one result item on out_valid/out_stall carrying
// status, match mask, topic length and payload length.
// Timing: filter writes, enables, the magic byte and payload bytes leave the
// block idle. A topic byte walks every slot through the filter memory: a
// comparing slot is read, then evaluated, a finished slot is passed over,
// and a slot crossing a '+' wildcard also steps past it; in_stall is high
// meanwhile. The last byte then passes through a result step.
// Throughput is bounded by the single read port of the filter memory.
// Reset clears enables, packet state and registers to their defaults;
// filter bytes are undefined until written. While the receiver stalls a
// result, the block finishes the next last byte only once the output
// register has been taken.
module topic_filter_packet_matcher #(
    parameter int NUM_FILTERS = tfpm_pkg::NUM_FILTERS_DEF,
    parameter int FILTER_LEN  = tfpm_pkg::FILTER_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [2:0]  slot,
    input  logic [4:0]  char_index,
    input  logic [7:0]  data_byte,
    input  logic        end_of_packet,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  match_mask,
    output logic [15:0] topic_length,
    output logic [15:0] payload_length
);

    import tfpm_pkg::*;

    localparam int DEPTH = NUM_FILTERS * FILTER_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
    localparam int PW    = $clog2(FILTER_LEN + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [SW-1:0] sidx_reg, sidx_next;
    logic [7:0]    char_reg, char_next;
    logic          eop_reg, eop_next;
    logic [15:0]   max_len_reg;
    logic [7:0]    magic_reg;
    logic [15:0]   bcount_reg, bcount_next;
    logic [15:0]   tcount_reg, tcount_next;
    logic          tend_reg, tend_next;
    logic          mok_reg, mok_next;
    logic          en_reg [NUM_FILTERS];
    logic          en_next [NUM_FILTERS];
    logic [PW-1:0] pos_reg [NUM_FILTERS];
    logic [PW-1:0] pos_next [NUM_FILTERS];
    logic [1:0]    phase_reg [NUM_FILTERS];
    logic [1:0]    phase_next [NUM_FILTERS];

    logic          ov_reg, ov_next;
    logic [2:0]    st_reg, st_next;
    logic [7:0]    mask_reg, mask_next;
    logic [15:0]   tlen_reg, tlen_next;
    logic [15:0]   plen_reg, plen_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_rdata;
    logic [7:0]    pchar;
    logic [1:0]    cur_phase;
    logic [PW-1:0] cur_pos;
    logic          accept;
    logic          last_slot;
    logic [2:0]    stat;
    logic [7:0]    mask_calc;

    tfpm_filter_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (data_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cur_phase = phase_reg[sidx_reg];
    assign cur_pos   = pos_reg[sidx_reg];
    assign last_slot = (32'(sidx_reg) == NUM_FILTERS - 1);

    // Filter memory addressing.
    assign mem_we = accept && (opcode == OP_WRITE_CHAR)
                    && (32'(slot) < NUM_FILTERS) && (32'(char_index) < FILTER_LEN);
    assign mem_waddr = AW'(slot) * AW'(FILTER_LEN) + AW'(char_index);
    assign mem_re    = (state_reg == S_STEP) && (cur_phase == PH_CMP);
    assign mem_raddr = AW'(sidx_reg) * AW'(FILTER_LEN) + AW'(cur_pos);

    // A position past the filter end reads as the terminator.
    assign pchar = (32'(cur_pos) < FILTER_LEN) ? mem_rdata : 8'd0;

    // Status and mask of the finished packet.
    always_comb
    begin
        if (bcount_reg <= 16'd2)
            stat = ST_SHORT;
        else if (bcount_reg >= max_len_reg || bcount_reg == COUNT_MAX)
            stat = ST_LONG;
        else if (!mok_reg)
            stat = ST_BAD_MAGIC;
        else if (!tend_reg)
            stat = ST_NO_TERM;
        else
            stat = ST_OK;
        mask_calc = '0;
        for (int s = 0; s < NUM_FILTERS && s < 8; s++)
        begin
            mask_calc[s] = en_reg[s] && (phase_reg[s] == PH_HIT);
        end
    end

    // Control sequencer.
    always_comb
    begin
        state_next  = state_reg;
        sidx_next   = sidx_reg;
        char_next   = char_reg;
        eop_next    = eop_reg;
        bcount_next = bcount_reg;
        tcount_next = tcount_reg;
        tend_next   = tend_reg;
        mok_next    = mok_reg;
        en_next     = en_reg;
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        ov_next     = ov_reg && out_stall;
        st_next     = st_reg;
        mask_next   = mask_reg;
        tlen_next   = tlen_reg;
        plen_next   = plen_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_ENABLE && 32'(slot) < NUM_FILTERS)
                    begin
                        en_next[SW'(slot)] = data_byte[0];
                    end
                    if (opcode == OP_PACKET)
                    begin
                        char_next = data_byte;
                        eop_next  = end_of_packet;
                        if (bcount_reg == '0)
                        begin
                            mok_next = (data_byte == magic_reg);
                        end
                        else if (!tend_reg)
                        begin
                            if (data_byte == 8'd0)
                                tend_next = 1'b1;
                            else if (tcount_reg != COUNT_MAX)
                                tcount_next = tcount_reg + 16'd1;
                        end
                        if (bcount_reg != COUNT_MAX)
                        begin
                            bcount_next = bcount_reg + 16'd1;
                        end
                        if (bcount_reg != '0 && !tend_reg)
                        begin
                            sidx_next  = '0;
                            state_next = S_STEP;
                        end
                        else if (end_of_packet)
                        begin
                            state_next = S_FIN;
                        end
                    end
                end
            end

            S_STEP:
            begin
                if (cur_phase == PH_CMP)
                begin
                    state_next = S_EVAL;
                end
                else if (cur_phase == PH_SKIP && (char_reg == 8'd0 || char_reg == CH_SLASH))
                begin
                    phase_next[sidx_reg] = PH_CMP;
                end
                else
                begin
                    sidx_next  = last_slot ? '0 : sidx_reg + 1'b1;
                    state_next = last_slot ? (eop_reg ? S_FIN : S_IDLE) : S_STEP;
                end
            end

            S_EVAL:
            begin
                sidx_next  = last_slot ? '0 : sidx_reg + 1'b1;
                state_next = last_slot ? (eop_reg ? S_FIN : S_IDLE) : S_STEP;
                if (pchar == 8'd0)
                begin
                    phase_next[sidx_reg] = (char_reg == 8'd0) ? PH_HIT : PH_MISS;
                end
                else if (pchar == CH_HASH)
                begin
                    phase_next[sidx_reg] = (char_reg != 8'd0) ? PH_HIT : PH_MISS;
                end
                else if (pchar == CH_PLUS)
                begin
                    phase_next[sidx_reg] = PH_SKIP;
                    pos_next[sidx_reg]   = cur_pos + 1'b1;
                    sidx_next            = sidx_reg;
                    state_next           = S_STEP;
                end
                else if (pchar != char_reg)
                begin
                    phase_next[sidx_reg] = PH_MISS;
                end
                else
                begin
                    pos_next[sidx_reg] = cur_pos + 1'b1;
                end
            end

            S_FIN:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next   = 1'b1;
                    st_next   = stat;
                    tlen_next = tcount_reg;
                    mask_next = (stat == ST_OK) ? mask_calc : 8'd0;
                    plen_next = (stat == ST_OK) ? (bcount_reg - tcount_reg - 16'd2) : 16'd0;
                    bcount_next = '0;
                    tcount_next = '0;
                    tend_next   = 1'b0;
                    mok_next    = 1'b0;
                    for (int s = 0; s < NUM_FILTERS; s++)
                    begin
                        pos_next[s]   = '0;
                        phase_next[s] = PH_CMP;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and packet state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sidx_reg   <= '0;
            eop_reg    <= 1'b0;
            bcount_reg <= '0;
            tcount_reg <= '0;
            tend_reg   <= 1'b0;
            mok_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            for (int s = 0; s < NUM_FILTERS; s++)
            begin
                en_reg[s]    <= 1'b0;
                pos_reg[s]   <= '0;
                phase_reg[s] <= PH_CMP;
            end
        end
        else
        begin
            state_reg  <= state_next;
            sidx_reg   <= sidx_next;
            eop_reg    <= eop_next;
            bcount_reg <= bcount_next;
            tcount_reg <= tcount_next;
            tend_reg   <= tend_next;
            mok_reg    <= mok_next;
            ov_reg     <= ov_next;
            en_reg     <= en_next;
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RST;
            magic_reg   <= MAGIC_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MAX_LEN)
                max_len_reg <= cfg_data;
            if (cfg_index == REG_MAGIC)
                magic_reg <= cfg_data[7:0];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        st_reg   <= st_next;
        mask_reg <= mask_next;
        tlen_reg <= tlen_next;
        plen_reg <= plen_next;
    end

    assign out_valid      = ov_reg;
    assign status         = st_reg;
    assign match_mask     = mask_reg;
    assign topic_length   = tlen_reg;
    assign payload_length = plen_reg;

endmodule

// ===== sv/tfpm_filter_mem.sv =====
// ============================================================================
// tfpm_filter_mem
// Filter character store: one write port, one read port, registered read.
// ============================================================================
module tfpm_filter_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tfpm_checker.sv =====
// ============================================================================
// tfpm_checker
// Port-level checks on the result channel of the packet matcher.
// ============================================================================
module tfpm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [7:0]  match_mask,
    input logic [15:0] payload_length
);

    import tfpm_pkg::*;

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Only ok packets report matches.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> match_mask == 8'd0)
        else $error("match mask set on failed packet");

    // Only ok packets report a payload length.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> payload_length == 16'd0)
        else $error("payload length set on failed packet");

    // Status is a defined code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_OK || status == ST_SHORT || status == ST_LONG
                      || status == ST_BAD_MAGIC || status == ST_NO_TERM)
        else $error("undefined status code");

endmodule

bind topic_filter_packet_matcher tfpm_checker u_tfpm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .match_mask     (match_mask),
    .payload_length (payload_length)
);

// ===== tb/topic_filter_packet_matcher_checker.sv =====
// ----------------------------------------------------------------------------
// topic_filter_packet_matcher_checker
// Watches both channels and the register port of the matcher, predicts every
// packet result from its own copy of the filter table and the packet state,
// and compares each result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module topic_filter_packet_matcher_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [2:0]  slot,
    input  logic [4:0]  char_index,
    input  logic [7:0]  data_byte,
    input  logic        end_of_packet,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [7:0]  match_mask,
    input  logic [15:0] topic_length,
    input  logic [15:0] payload_length,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tfpm_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  mask;
        logic [15:0] topic_bytes;
        logic [15:0] payload_len;
    } verdict_t;

    verdict_t    verdict_q[$];

    logic [15:0] max_len;
    logic [7:0]  magic;
    logic [7:0]  filt_mem[NUM_FILTERS_DEF][FILTER_LEN_DEF];
    logic        slot_on[NUM_FILTERS_DEF];
    int          pat_pos[NUM_FILTERS_DEF];
    logic [1:0]  slot_phase[NUM_FILTERS_DEF];
    logic [15:0] byte_cnt;
    logic [15:0] topic_cnt;
    logic        topic_done;
    logic        magic_ok;

    assign pending = verdict_q.size();

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Clear the per-packet part of the state.
    function automatic void clear_packet();
        for (int s = 0; s < NUM_FILTERS_DEF; s++)
        begin
            pat_pos[s]    = 0;
            slot_phase[s] = PH_CMP;
        end
        byte_cnt   = '0;
        topic_cnt  = '0;
        topic_done = 1'b0;
        magic_ok   = 1'b0;
    endfunction

    // Advance one slot's wildcard match by one topic byte; zero ends the topic.
    function automatic void advance_slot(int s, logic [7:0] c);
        logic [7:0] p;
        forever
        begin
            if (slot_phase[s] == PH_HIT || slot_phase[s] == PH_MISS)
                return;
            if (slot_phase[s] == PH_SKIP)
            begin
                if (c != 8'd0 && c != CH_SLASH)
                    return;
                slot_phase[s] = PH_CMP;
                continue;
            end
            p = (pat_pos[s] < FILTER_LEN_DEF) ? filt_mem[s][pat_pos[s]] : 8'd0;
            if (p == 8'd0)
            begin
                slot_phase[s] = (c == 8'd0) ? PH_HIT : PH_MISS;
                return;
            end
            if (p == CH_HASH)
            begin
                slot_phase[s] = (c != 8'd0) ? PH_HIT : PH_MISS;
                return;
            end
            if (p == CH_PLUS)
            begin
                slot_phase[s] = PH_SKIP;
                pat_pos[s]++;
                continue;
            end
            if (p != c)
            begin
                slot_phase[s] = PH_MISS;
                return;
            end
            pat_pos[s]++;
            return;
        end
    endfunction

    // Apply one accepted item; a last packet byte queues its result.
    function automatic void absorb_item(logic [1:0] op, logic [2:0] sl, logic [4:0] ci,
                                        logic [7:0] b, logic eop);
        verdict_t v;
        if (op == OP_WRITE_CHAR)
        begin
            filt_mem[sl][ci] = b;
            return;
        end
        if (op == OP_ENABLE)
        begin
            slot_on[sl] = b[0];
            return;
        end
        if (op != OP_PACKET)
            return;
        if (byte_cnt == 16'd0)
            magic_ok = (b == magic);
        else if (!topic_done)
        begin
            if (b == 8'd0)
                topic_done = 1'b1;
            else if (topic_cnt != COUNT_MAX)
                topic_cnt++;
            for (int s = 0; s < NUM_FILTERS_DEF; s++)
                advance_slot(s, b);
        end
        if (byte_cnt != COUNT_MAX)
            byte_cnt++;
        if (!eop)
            return;
        v = '0;
        if (byte_cnt <= 16'd2)
            v.status = ST_SHORT;
        else if (byte_cnt >= max_len || byte_cnt == COUNT_MAX)
            v.status = ST_LONG;
        else if (!magic_ok)
            v.status = ST_BAD_MAGIC;
        else if (!topic_done)
            v.status = ST_NO_TERM;
        else
            v.status = ST_OK;
        if (v.status == ST_OK)
        begin
            for (int s = 0; s < NUM_FILTERS_DEF; s++)
                if (slot_on[s] && slot_phase[s] == PH_HIT)
                    v.mask[s] = 1'b1;
            v.payload_len = byte_cnt - topic_cnt - 16'd2;
        end
        v.topic_bytes = topic_cnt;
        verdict_q.push_back(v);
        clear_packet();
    endfunction

    // Watch the channels: results are compared before the same edge's input.
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t w;
        if (!rst_n)
        begin
            max_len = MAX_LEN_RST;
            magic   = MAGIC_RST;
            for (int s = 0; s < NUM_FILTERS_DEF; s++)
                slot_on[s] = 1'b0;
            clear_packet();
            verdict_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                    report("result item with none expected", {13'd0, status}, 16'd0);
                else
                begin
                    w = verdict_q.pop_front();
                    if (status !== w.status)
                        report("status", {13'd0, status}, {13'd0, w.status});
                    if (match_mask !== w.mask)
                        report("match_mask", {8'd0, match_mask}, {8'd0, w.mask});
                    if (topic_length !== w.topic_bytes)
                        report("topic_length", topic_length, w.topic_bytes);
                    if (payload_length !== w.payload_len)
                        report("payload_length", payload_length, w.payload_len);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_MAX_LEN)
                    max_len = cfg_data;
                else
                    magic = cfg_data[7:0];
            end
            if (in_valid && !in_stall)
                absorb_item(opcode, slot, char_index, data_byte, end_of_packet);
        end
    end

endmodule

// ===== tb/topic_filter_packet_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// topic_filter_packet_matcher_tb
// Drives filter loads, enables and packets into the matcher under several
// idle and stall patterns and register settings; the checker beside the
// block predicts and compares every result item.
// ----------------------------------------------------------------------------
module topic_filter_packet_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tfpm_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = '0;
    logic [2:0]  slot = '0;
    logic [4:0]  char_index = '0;
    logic [7:0]  data_byte = '0;
    logic        end_of_packet = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [7:0]  match_mask;
    logic [15:0] topic_length;
    logic [15:0] payload_length;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int cycle_cnt = 0;
    int sent_items = 0;

    always #1 clk = ~clk;

    topic_filter_packet_matcher u_top (.*);

    topic_filter_packet_matcher_checker u_chk (.*);

    // Run-time guard.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("topic_filter_packet_matcher: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Offer one item and wait until the block takes it.
    task automatic send(input logic [1:0] op, input logic [2:0] sl, input logic [4:0] ci,
                        input logic [7:0] b, input logic eop);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        opcode        = op;
        slot          = sl;
        char_index    = ci;
        data_byte     = b;
        end_of_packet = eop;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        @(negedge clk);
        in_valid = 1'b0;
        sent_items++;
    endtask

    // Register write once every result is out and the block has settled.
    task automatic cfg_write(input logic idx, input logic [15:0] val);
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [7:0] pick_char(input bit wild);
        int r;
        r = $urandom_range(wild ? 5 : 3);
        case (r)
            0: return "a";
            1: return "b";
            2: return CH_SLASH;
            3: return "c";
            4: return CH_PLUS;
            default: return CH_HASH;
        endcase
    endfunction

    // Load a short random wildcard filter into one slot.
    task automatic load_filter(input logic [2:0] sl);
        int n;
        n = $urandom_range(6);
        for (int i = 0; i < n; i++)
            send(OP_WRITE_CHAR, sl, 5'(i), pick_char(1), 1'($urandom_range(1)));
        send(OP_WRITE_CHAR, sl, 5'(n), 8'd0, 1'b0);
    endtask

    // One packet: mostly well formed with a small-alphabet topic.
    task automatic send_packet(input logic [7:0] mg);
        int tl;
        int pl;
        int kind;
        kind = $urandom_range(19);
        tl = $urandom_range(8);
        pl = $urandom_range(6);
        if (kind == 0)
        begin
            // Short packet of one or two bytes.
            if ($urandom_range(1))
                send(OP_PACKET, 3'($urandom), 5'($urandom), 8'($urandom), 1'b1);
            else
            begin
                send(OP_PACKET, 3'($urandom), 5'($urandom), mg, 1'b0);
                send(OP_PACKET, 3'($urandom), 5'($urandom), 8'($urandom), 1'b1);
            end
            return;
        end
        send(OP_PACKET, 3'($urandom), 5'($urandom), (kind == 1) ? 8'($urandom) : mg, 1'b0);
        for (int i = 0; i < tl; i++)
        begin
            send(OP_PACKET, 3'($urandom), 5'($urandom),
                 (kind == 2) ? 8'($urandom_range(255, 1)) : pick_char(0), 1'b0);
            // Occasional filter or enable change in the middle of a topic.
            if (kind == 3)
                send(OP_WRITE_CHAR, 3'($urandom), 5'($urandom_range(7)), pick_char(1), 1'b0);
            if (kind == 4)
                send(OP_ENABLE, 3'($urandom), 5'($urandom), 8'($urandom), 1'b1);
        end
        if (kind == 5)
        begin
            // No terminator.
            send(OP_PACKET, 3'($urandom), 5'($urandom), 8'($urandom_range(255, 1)), 1'b1);
            return;
        end
        send(OP_PACKET, 3'($urandom), 5'($urandom), 8'd0, (pl == 0));
        for (int i = 0; i < pl; i++)
            send(OP_PACKET, 3'($urandom), 5'($urandom), 8'($urandom), (i == pl - 1));
    endtask

    // Random mix of packets, filter loads, enables and ignored items.
    task automatic run_random(input int n, input logic [7:0] mg);
        int r;
        int stop;
        stop = sent_items + n;
        while (sent_items < stop)
        begin
            r = $urandom_range(99);
            if (r < 70)
                send_packet(mg);
            else if (r < 80)
                load_filter(3'($urandom));
            else if (r < 90)
                send(OP_ENABLE, 3'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
            else
                send(OP_RESERVED, 3'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Give every filter byte a defined value first.
        for (int s = 0; s < NUM_FILTERS_DEF; s++)
            for (int i = 0; i < FILTER_LEN_DEF; i++)
                send(OP_WRITE_CHAR, 3'(s), 5'(i), 8'd0, 1'b0);

        // Directed: a full filter, wildcards, every status but long.
        for (int i = 0; i < FILTER_LEN_DEF; i++)
            send(OP_WRITE_CHAR, 3'd7, 5'(i), "a", 1'b0);
        send(OP_WRITE_CHAR, 3'd0, 5'd0, CH_PLUS, 1'b0);
        send(OP_WRITE_CHAR, 3'd1, 5'd0, CH_HASH, 1'b0);
        send(OP_ENABLE, 3'd7, 5'd0, 8'hFF, 1'b0);
        send(OP_ENABLE, 3'd0, 5'd0, 8'h01, 1'b0);
        send(OP_ENABLE, 3'd1, 5'd0, 8'h01, 1'b0);
        send(OP_ENABLE, 3'd2, 5'd31, 8'h01, 1'b1);
        send(OP_PACKET, 3'd0, 5'd0, MAGIC_RST, 1'b0);
        for (int i = 0; i < FILTER_LEN_DEF; i++)
            send(OP_PACKET, 3'd0, 5'd0, "a", 1'b0);
        send(OP_PACKET, 3'd0, 5'd0, 8'd0, 1'b0);
        send(OP_PACKET, 3'd0, 5'd0, 8'hFF, 1'b1);
        // Empty topic in a two-byte packet: reported as short, so no match is shown.
        send(OP_PACKET, 3'd0, 5'd0, MAGIC_RST, 1'b0);
        send(OP_PACKET, 3'd0, 5'd0, 8'd0, 1'b1);
        send(OP_PACKET, 3'd0, 5'd0, 8'h00, 1'b1);
        send(OP_PACKET, 3'd0, 5'd0, 8'hAF, 1'b0);
        send(OP_PACKET, 3'd0, 5'd0, "a", 1'b0);
        send(OP_PACKET, 3'd0, 5'd0, 8'd0, 1'b1);
        send(OP_PACKET, 3'd0, 5'd0, MAGIC_RST, 1'b0);
        send(OP_PACKET, 3'd0, 5'd0, "b", 1'b0);
        send(OP_PACKET, 3'd0, 5'd0, "/", 1'b1);
        send(OP_RESERVED, 3'd7, 5'd31, 8'hFF, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 78 : ((ph == 3) ? 10 : 0);
            recv_stall_pct = (ph == 2 || ph == 3) ? 78 : 0;
            if (ph == 3)
            begin
                send_idle_pct  = 10;
                recv_stall_pct = 10;
            end
            case (ph)
                0:
                begin
                    cfg_write(REG_MAX_LEN, 16'd65535);
                    cfg_write(REG_MAGIC, 16'd0);
                    run_random(500, 8'd0);
                end
                1:
                begin
                    cfg_write(REG_MAX_LEN, 16'd3);
                    cfg_write(REG_MAGIC, 16'd255);
                    run_random(150, 8'd255);
                    cfg_write(REG_MAX_LEN, 16'd9);
                    run_random(350, 8'd255);
                end
                2:
                begin
                    cfg_write(REG_MAX_LEN, MAX_LEN_RST);
                    cfg_write(REG_MAGIC, 16'(MAGIC_RST));
                    hold_cycles = 600;
                    run_random(500, MAGIC_RST);
                end
                default:
                begin
                    cfg_write(REG_MAX_LEN, 16'd12);
                    cfg_write(REG_MAGIC, 16'h00A5);
                    run_random(500, 8'hA5);
                end
            endcase
        end

        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("topic_filter_packet_matcher: match");
        else
            $display("topic_filter_packet_matcher: mismatch");
        $finish;
    end

endmodule
